[hdl/sfc_pkg.sv]
// shared types, constants and the crc-8 byte update for the status frame checker
// no dependencies; every other file of the block uses this package
package sfc_pkg;

    localparam int STATUS_BYTES_DEF = 8;
    localparam int BYTE_W           = 8;
    localparam int POS_W            = 9;
    localparam int STATUS_W         = 64;
    localparam int VERDICT_W        = 3;

    localparam logic [POS_W-1:0]  POS_MAX      = '1;
    localparam logic [POS_W-1:0]  POS_HEADER   = POS_W'(0);
    localparam logic [POS_W-1:0]  POS_COMMAND  = POS_W'(1);
    localparam logic [POS_W-1:0]  POS_LENGTH   = POS_W'(2);
    localparam logic [POS_W-1:0]  POS_PAYLOAD  = POS_W'(3);
    localparam logic [POS_W-1:0]  POS_MIN_LEN  = POS_W'(4);
    localparam logic [BYTE_W-1:0] CRC_POLY     = 8'h07;
    localparam logic [BYTE_W-1:0] CRC_INIT     = 8'h00;
    localparam logic [BYTE_W-1:0] CRC_TOP_BIT  = 8'h80;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_SHORT     = 3'd1,
        VERDICT_BAD_HDR   = 3'd2,
        VERDICT_TRUNCATED = 3'd3,
        VERDICT_CRC_BAD   = 3'd4,
        VERDICT_LEN_SHORT = 3'd5
    } t_verdict;

    typedef struct packed {
        t_verdict              verdict;
        logic [STATUS_W-1:0]   status;
    } t_result;

    // msb-first crc-8 over one byte, no final xor
    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int i = 0; i < BYTE_W; i++) begin
            if ((c & CRC_TOP_BIT) != '0) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

[hdl/sfc_if.sv]
// valid/ready channel interfaces: received bytes, results and the header config write
// depends on sfc_pkg for widths and types
interface sfc_in_if;
    logic                        valid;
    logic                        ready;
    logic [sfc_pkg::BYTE_W-1:0]  rx_byte;
    logic                        buffer_start;
    logic                        buffer_end;
    modport source (output valid, output rx_byte, output buffer_start, output buffer_end,
                    input ready);
    modport sink   (input valid, input rx_byte, input buffer_start, input buffer_end,
                    output ready);
endinterface

interface sfc_out_if;
    logic                          valid;
    logic                          ready;
    logic [sfc_pkg::VERDICT_W-1:0] verdict;
    logic [sfc_pkg::STATUS_W-1:0]  status_value;
    modport source (output valid, output verdict, output status_value, input ready);
    modport sink   (input valid, input verdict, input status_value, output ready);
endinterface

interface sfc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [sfc_pkg::BYTE_W-1:0]  expected_header;
    modport source (output valid, output expected_header, input ready);
    modport sink   (input valid, input expected_header, output ready);
endinterface

[hdl/sfc_frame_state.sv]
// per-buffer tracking: position, length, running crc, check flags and status capture
// depends on sfc_pkg; produces one result on the accepted last byte of a buffer
module sfc_frame_state #(
    parameter int STATUS_BYTES = sfc_pkg::STATUS_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [sfc_pkg::BYTE_W-1:0]   i_rx_byte,
    input  logic                         i_buffer_start,
    input  logic                         i_buffer_end,
    input  logic [sfc_pkg::BYTE_W-1:0]   i_expected_header,
    output logic                         o_result_valid,
    output sfc_pkg::t_result             o_result
);

    localparam int CAP_W = sfc_pkg::BYTE_W * STATUS_BYTES;

    logic [sfc_pkg::POS_W-1:0]  r_pos,     n_pos;
    logic [sfc_pkg::BYTE_W-1:0] r_len,     n_len;
    logic [sfc_pkg::BYTE_W-1:0] r_crc,     n_crc;
    logic                       r_hdr_ok,  n_hdr_ok;
    logic                       r_crc_ok,  n_crc_ok;
    logic                       r_crc_seen, n_crc_seen;
    logic [CAP_W-1:0]           r_cap,     n_cap;

    logic [sfc_pkg::POS_W-1:0]  c_pos;
    logic [sfc_pkg::BYTE_W-1:0] c_len;
    logic [sfc_pkg::BYTE_W-1:0] c_crc;
    logic                       c_hdr_ok, c_crc_ok, c_crc_seen;
    logic [CAP_W-1:0]           c_cap;
    logic [sfc_pkg::POS_W-1:0]  crc_pos;
    logic [sfc_pkg::BYTE_W-1:0] crc_next;
    logic [sfc_pkg::POS_W-1:0]  u_pos;
    logic [sfc_pkg::BYTE_W-1:0] u_len, u_crc;
    logic                       u_hdr_ok, u_crc_ok, u_crc_seen;
    logic [CAP_W-1:0]           u_cap;
    sfc_pkg::t_verdict          verdict;

    // start of buffer clears the state before its byte is taken
    always_comb begin
        if (i_buffer_start) begin
            c_pos      = '0;
            c_len      = '0;
            c_crc      = sfc_pkg::CRC_INIT;
            c_hdr_ok   = 1'b0;
            c_crc_ok   = 1'b0;
            c_crc_seen = 1'b0;
            c_cap      = '0;
        end else begin
            c_pos      = r_pos;
            c_len      = r_len;
            c_crc      = r_crc;
            c_hdr_ok   = r_hdr_ok;
            c_crc_ok   = r_crc_ok;
            c_crc_seen = r_crc_seen;
            c_cap      = r_cap;
        end
    end

    assign crc_pos  = sfc_pkg::POS_PAYLOAD + sfc_pkg::POS_W'(c_len);
    assign crc_next = sfc_pkg::crc8_byte(c_crc, i_rx_byte);

    // payload capture, one byte lane per status byte
    always_comb begin
        u_cap = c_cap;
        for (int k = 0; k < STATUS_BYTES; k++) begin
            if (c_pos == sfc_pkg::POS_PAYLOAD + sfc_pkg::POS_W'(k)) begin
                u_cap[k*sfc_pkg::BYTE_W +: sfc_pkg::BYTE_W] = i_rx_byte;
            end
        end
    end

    always_comb begin
        u_len      = c_len;
        u_crc      = c_crc;
        u_hdr_ok   = c_hdr_ok;
        u_crc_ok   = c_crc_ok;
        u_crc_seen = c_crc_seen;
        if (c_pos == sfc_pkg::POS_HEADER) begin
            u_hdr_ok = (i_rx_byte == i_expected_header);
            u_crc    = crc_next;
        end else if (c_pos == sfc_pkg::POS_COMMAND) begin
            u_crc    = crc_next;
        end else if (c_pos == sfc_pkg::POS_LENGTH) begin
            u_len    = i_rx_byte;
            u_crc    = crc_next;
        end else if (c_pos < crc_pos) begin
            u_crc    = crc_next;
        end else if (c_pos == crc_pos) begin
            u_crc_seen = 1'b1;
            u_crc_ok   = (c_crc == i_rx_byte);
        end
        u_pos = (c_pos < sfc_pkg::POS_MAX) ? c_pos + sfc_pkg::POS_W'(1) : c_pos;
    end

    // checks in priority order
    always_comb begin
        if (u_pos < sfc_pkg::POS_MIN_LEN) begin
            verdict = sfc_pkg::VERDICT_SHORT;
        end else if (!u_hdr_ok) begin
            verdict = sfc_pkg::VERDICT_BAD_HDR;
        end else if (!u_crc_seen) begin
            verdict = sfc_pkg::VERDICT_TRUNCATED;
        end else if (!u_crc_ok) begin
            verdict = sfc_pkg::VERDICT_CRC_BAD;
        end else if (u_len < sfc_pkg::BYTE_W'(STATUS_BYTES)) begin
            verdict = sfc_pkg::VERDICT_LEN_SHORT;
        end else begin
            verdict = sfc_pkg::VERDICT_OK;
        end
    end

    assign o_result_valid = i_accept && i_buffer_end;

    always_comb begin
        o_result.verdict = verdict;
        o_result.status  = (verdict == sfc_pkg::VERDICT_OK) ?
                           sfc_pkg::STATUS_W'(u_cap) : '0;
    end

    // verdict clears the state so the next byte opens a new buffer
    always_comb begin
        n_pos      = r_pos;
        n_len      = r_len;
        n_crc      = r_crc;
        n_hdr_ok   = r_hdr_ok;
        n_crc_ok   = r_crc_ok;
        n_crc_seen = r_crc_seen;
        n_cap      = r_cap;
        if (i_accept) begin
            if (i_buffer_end) begin
                n_pos      = '0;
                n_len      = '0;
                n_crc      = sfc_pkg::CRC_INIT;
                n_hdr_ok   = 1'b0;
                n_crc_ok   = 1'b0;
                n_crc_seen = 1'b0;
                n_cap      = '0;
            end else begin
                n_pos      = u_pos;
                n_len      = u_len;
                n_crc      = u_crc;
                n_hdr_ok   = u_hdr_ok;
                n_crc_ok   = u_crc_ok;
                n_crc_seen = u_crc_seen;
                n_cap      = u_cap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_len      <= '0;
            r_crc      <= sfc_pkg::CRC_INIT;
            r_hdr_ok   <= 1'b0;
            r_crc_ok   <= 1'b0;
            r_crc_seen <= 1'b0;
            r_cap      <= '0;
        end else begin
            r_pos      <= n_pos;
            r_len      <= n_len;
            r_crc      <= n_crc;
            r_hdr_ok   <= n_hdr_ok;
            r_crc_ok   <= n_crc_ok;
            r_crc_seen <= n_crc_seen;
            r_cap      <= n_cap;
        end
    end

endmodule

[hdl/sfc_out_reg.sv]
// result register between the checker and the downstream sink
// depends on sfc_pkg for the result type
module sfc_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  sfc_pkg::t_result  i_data,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_ready,
    output sfc_pkg::t_result  o_data
);

    logic             r_valid, n_valid;
    sfc_pkg::t_result r_data,  n_data;

    assign o_can_load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (o_can_load) begin
            n_valid = i_load;
            if (i_load) begin
                n_data = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[hdl/status_frame_checker_crc8.sv]
// a verdict is registered and shown in the cycle after the transfer of the buffer's last byte
// throughput: one byte per cycle unless the input stalls; the crc-8 byte update and the checks are combinational
// the input stalls only while a finished verdict waits in the result register
// reset (synchronous, active low) clears the frame state, the result register's valid
// flag and the expected header, which starts at zero
module status_frame_checker_crc8 #(
    parameter int STATUS_BYTES = sfc_pkg::STATUS_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sfc_in_if.sink        i_rx,
    sfc_out_if.source     o_res,
    sfc_cfg_if.sink       i_cfg
);

    // expected header register, written through its own channel
    logic [sfc_pkg::BYTE_W-1:0] r_header, n_header;

    // byte transfer and result handoff
    logic              rx_accept;
    logic              can_load;
    logic              result_valid;
    sfc_pkg::t_result  result;
    sfc_pkg::t_result  res_data;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_header = r_header;
        if (i_cfg.valid) begin
            n_header = i_cfg.expected_header;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= '0;
        end else begin
            r_header <= n_header;
        end
    end

    // a byte is taken whenever the result register can take a verdict
    assign i_rx.ready = can_load;
    assign rx_accept  = i_rx.valid && can_load;

    sfc_frame_state #(
        .STATUS_BYTES (STATUS_BYTES)
    ) u_state (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (rx_accept),
        .i_rx_byte         (i_rx.rx_byte),
        .i_buffer_start    (i_rx.buffer_start),
        .i_buffer_end      (i_rx.buffer_end),
        .i_expected_header (r_header),
        .o_result_valid    (result_valid),
        .o_result          (result)
    );

    // result register: a byte is taken with a verdict held only if the sink takes it
    sfc_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (result_valid),
        .i_data     (result),
        .o_can_load (can_load),
        .o_valid    (o_res.valid),
        .i_ready    (o_res.ready),
        .o_data     (res_data)
    );

    assign o_res.verdict      = res_data.verdict;
    assign o_res.status_value = res_data.status;

endmodule

[tb/sv/status_frame_checker_crc8_test.sv]
// testbench for status_frame_checker_crc8: drives received buffers byte by byte,
// predicts each verdict and status value, and checks every result transfer in order
// depends on sfc_pkg and the channel interfaces in sfc_if.sv
`timescale 1ns / 1ps

module status_frame_checker_crc8_test;

    localparam int N_STATUS     = sfc_pkg::STATUS_BYTES_DEF;
    localparam int HOLD_CYCLES  = 200;     // long receiver hold-off
    localparam int DRAIN_CYCLES = 3;       // verdict shows in the cycle after the last byte
    localparam int STALL_LIMIT  = 2000;    // cycles without any transfer before giving up

    logic i_clk = 1'b0;
    logic i_rst_n;

    sfc_in_if  rx_if ();
    sfc_out_if res_if ();
    sfc_cfg_if cfg_if ();

    status_frame_checker_crc8 #(
        .STATUS_BYTES (N_STATUS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if.sink),
        .o_res   (res_if.source),
        .i_cfg   (cfg_if.sink)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // shadow of the checker state, updated on each accepted byte transfer
    // ------------------------------------------------------------------
    logic [7:0]                   hdr_cfg;
    logic [sfc_pkg::POS_W-1:0]    frame_pos;
    logic [7:0]                   frame_len;
    logic [7:0]                   crc_acc;
    logic                         hdr_match;
    logic                         crc_match;
    logic                         crc_reached;
    logic [sfc_pkg::STATUS_W-1:0] status_acc;

    sfc_pkg::t_result exp_verdicts[$];   // verdicts still owed by the block, oldest first
    logic [7:0]       frame_bytes[$];    // buffer being assembled by the current test

    int n_errors = 0;

    // stimulus knobs shared by the tests
    bit no_gaps   = 1'b0;   // sender offers back to back
    bit rx_stalls = 1'b1;   // receiver drops ready at random
    bit hold_req  = 1'b0;   // receiver holds off for HOLD_CYCLES

    // msb-first crc-8, one input bit per step
    function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] din);
        logic [7:0] r;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            r = {r[6:0], 1'b0} ^ ((r[7] ^ din[k]) ? sfc_pkg::CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    function automatic void clear_frame_state();
        frame_pos   = '0;
        frame_len   = '0;
        crc_acc     = sfc_pkg::CRC_INIT;
        hdr_match   = 1'b0;
        crc_match   = 1'b0;
        crc_reached = 1'b0;
        status_acc  = '0;
    endfunction

    // advance the shadow state by one byte; on the last byte queue the verdict
    function automatic void track_byte(input logic [7:0] b, input bit s, input bit e);
        int               p;
        int               crc_at;
        sfc_pkg::t_result want;
        if (s) begin
            clear_frame_state();
        end
        p      = int'(frame_pos);
        crc_at = 3 + int'(frame_len);
        if (p == 0) begin
            hdr_match = (b == hdr_cfg);
            crc_acc   = crc_next(crc_acc, b);
        end else if (p == 1) begin
            crc_acc = crc_next(crc_acc, b);
        end else if (p == 2) begin
            frame_len = b;
            crc_acc   = crc_next(crc_acc, b);
        end else begin
            // payload offsets 3 .. 2+N_STATUS land little-endian in the status word
            if (p < 3 + N_STATUS) begin
                status_acc |= sfc_pkg::STATUS_W'(b) << (8 * ((p - 3) & 7));
            end
            if (p < crc_at) begin
                crc_acc = crc_next(crc_acc, b);
            end else if (p == crc_at) begin
                crc_reached = 1'b1;
                crc_match   = (crc_acc == b);
            end
        end
        // position sticks at its top value on very long buffers
        if (frame_pos != sfc_pkg::POS_MAX) begin
            frame_pos = frame_pos + 1'b1;
        end
        if (e) begin
            want.status = '0;
            // first failing check wins
            if (frame_pos < sfc_pkg::POS_MIN_LEN) begin
                want.verdict = sfc_pkg::VERDICT_SHORT;
            end else if (!hdr_match) begin
                want.verdict = sfc_pkg::VERDICT_BAD_HDR;
            end else if (!crc_reached) begin
                want.verdict = sfc_pkg::VERDICT_TRUNCATED;
            end else if (!crc_match) begin
                want.verdict = sfc_pkg::VERDICT_CRC_BAD;
            end else if (int'(frame_len) < N_STATUS) begin
                want.verdict = sfc_pkg::VERDICT_LEN_SHORT;
            end else begin
                want.verdict = sfc_pkg::VERDICT_OK;
                want.status  = status_acc;
            end
            exp_verdicts.push_back(want);
            clear_frame_state();
        end
    endfunction

    // idle length: mostly short, now and then long
    function automatic int pick_idle_len();
        if ($urandom_range(0, 99) < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_gap();
        if (no_gaps || $urandom_range(0, 99) < 60) begin
            return 0;
        end
        return pick_idle_len();
    endfunction

    // payload length: mostly small, a few up to the full byte range
    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 8'($urandom_range(0, 16));
        end else if (r < 95) begin
            return 8'($urandom_range(17, 40));
        end
        return 8'($urandom_range(41, 255));
    endfunction

    // well-formed frame, its crc spoiled when crc_bad is set; fill < 0 means random command and payload bytes
    function automatic void build_frame(input logic [7:0] hdr, input logic [7:0] len,
                                        input bit crc_bad, input int fill);
        logic [7:0] crc;
        logic [7:0] b;
        frame_bytes.delete();
        crc = sfc_pkg::CRC_INIT;
        for (int i = 0; i < 3 + int'(len); i++) begin
            if (i == 0) begin
                b = hdr;
            end else if (i == 2) begin
                b = len;
            end else begin
                b = (fill < 0) ? 8'($urandom) : 8'(fill);
            end
            frame_bytes.push_back(b);
            crc = crc_next(crc, b);
        end
        if (crc_bad) begin
            crc ^= 8'($urandom_range(1, 255));
        end
        frame_bytes.push_back(crc);
    endfunction

    function automatic void add_trailing(input int n);
        repeat (n) frame_bytes.push_back(8'($urandom));
    endfunction

    function automatic void cut_to(input int n);
        while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
    endfunction

    // ------------------------------------------------------------------
    // byte sender: changes inputs at the falling edge, waits for the transfer
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input bit s, input bit e);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            rx_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        rx_if.valid        <= 1'b1;
        rx_if.rx_byte      <= b;
        rx_if.buffer_start <= s;
        rx_if.buffer_end   <= e;
        do @(posedge i_clk); while (rx_if.ready !== 1'b1);
        track_byte(b, s, e);
    endtask

    // whole assembled buffer; the end mark goes on its last byte
    task automatic send_buffer(input bit with_start);
        int n;
        n = frame_bytes.size();
        for (int i = 0; i < n; i++) begin
            send_byte(frame_bytes[i], with_start && i == 0, i == n - 1);
        end
    endtask

    // drop valid, then wait for every owed verdict plus DRAIN_CYCLES of slack
    task automatic wait_drained();
        @(negedge i_clk);
        rx_if.valid <= 1'b0;
        while (exp_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // header register write, only with the block idle
    task automatic write_header(input logic [7:0] v);
        wait_drained();
        @(negedge i_clk);
        cfg_if.valid           <= 1'b1;
        cfg_if.expected_header <= v;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        hdr_cfg = v;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side: random ready, plus the long hold-off on request
    // ------------------------------------------------------------------
    always begin
        @(negedge i_clk);
        if (hold_req) begin
            res_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge i_clk);
            hold_req = 1'b0;
        end else if (rx_stalls && $urandom_range(0, 99) < 30) begin
            res_if.ready <= 1'b0;
            repeat (pick_idle_len() - 1) @(negedge i_clk);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        n_errors++;
    endtask

    // every result transfer is compared with the oldest owed verdict
    always @(posedge i_clk) begin
        sfc_pkg::t_result want;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (exp_verdicts.size() == 0) begin
                report_mismatch($sformatf("result transfer with none pending, verdict %0d",
                                          res_if.verdict));
            end else begin
                want = exp_verdicts.pop_front();
                if (res_if.verdict !== want.verdict) begin
                    report_mismatch($sformatf("verdict got %0d want %0d",
                                              res_if.verdict, want.verdict));
                end
                if (res_if.status_value !== want.status) begin
                    report_mismatch($sformatf("status got %h want %h",
                                              res_if.status_value, want.status));
                end
            end
        end
    end

    // watchdog: too long without a transfer on any channel ends the run
    int idle_count = 0;
    always @(posedge i_clk) begin
        if ((rx_if.valid === 1'b1 && rx_if.ready === 1'b1) ||
            (res_if.valid === 1'b1 && res_if.ready === 1'b1) ||
            (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
            idle_count <= 0;
        end else if (idle_count >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // at least one buffer per verdict, starting with the header left at its reset value
    task automatic test_verdicts();
        // header still zero after reset, len 0 gives payload too short
        build_frame(8'h00, 8'd0, 1'b0, -1);
        send_buffer(1'b1);
        write_header(8'hA5);
        // start and end on the same byte
        send_byte(8'hA5, 1'b1, 1'b1);
        // three bytes are still too few
        build_frame(8'hA5, 8'd0, 1'b0, -1);
        cut_to(3);
        send_buffer(1'b1);
        // wrong header
        build_frame(8'h5A, 8'd0, 1'b0, -1);
        send_buffer(1'b1);
        // buffer ends before the crc byte
        build_frame(8'hA5, 8'd6, 1'b0, -1);
        cut_to(5);
        send_buffer(1'b1);
        // crc mismatch
        build_frame(8'hA5, 8'd0, 1'b1, -1);
        send_buffer(1'b1);
        // good frame, status captured, trailing bytes ignored, no start mark
        build_frame(8'hA5, 8'd8, 1'b0, 8'hFF);
        add_trailing(2);
        send_buffer(1'b0);
    endtask

    // a cut buffer with no start mark, a full one with a start mark, then a buffer after a verdict with no start
    task automatic test_restart();
        build_frame(8'hA5, 8'd20, 1'b0, -1);
        cut_to(3);
        send_buffer(1'b0);
        build_frame(8'hA5, 8'd8, 1'b0, -1);
        send_buffer(1'b1);
        build_frame(8'hA5, 8'd10, 1'b0, -1);
        send_buffer(1'b0);
    endtask

    // header register and bytes at both ends of their range
    task automatic test_extremes();
        write_header(8'hFF);
        build_frame(8'hFF, 8'd8, 1'b0, 8'hFF);
        send_buffer(1'b1);
        write_header(8'h00);
        build_frame(8'h00, 8'd8, 1'b0, 8'h00);
        send_buffer(1'b1);
        build_frame(8'h00, 8'hFF, 1'b0, -1);
        cut_to(12);
        send_buffer(1'b1);
    endtask

    // receiver stops while back-to-back buffers keep coming, so the input stalls
    task automatic test_backpressure();
        write_header(8'h3C);
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        repeat (4) begin
            build_frame(8'h3C, 8'd8, 1'b0, -1);
            send_buffer(1'b1);
        end
        no_gaps = 1'b0;
        wait_drained();
    endtask

    // buffer running past the saturated position
    task automatic test_long_buffer();
        build_frame(8'h3C, 8'hFF, 1'b0, -1);
        add_trailing(260);
        send_buffer(1'b1);
    endtask

    // well-formed frames with random content, broken ones and noise
    task automatic test_random_phase(input logic [7:0] hdr, input int target, input bit quiet);
        int sent;
        int kind;
        int n;
        write_header(hdr);
        no_gaps   = quiet;
        rx_stalls = !quiet;
        sent      = 0;
        while (sent < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 15) begin
                // raw bytes with random marks, always closed by an end mark
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++) begin
                    send_byte(8'($urandom), $urandom_range(0, 99) < 20,
                              i == n - 1 || $urandom_range(0, 99) < 5);
                end
                sent += n;
            end else begin
                build_frame((kind >= 65 && kind < 73) ? hdr_cfg ^ 8'($urandom_range(1, 255))
                                                      : hdr_cfg,
                            pick_len(), kind >= 55 && kind < 65, -1);
                if (kind >= 73 && kind < 93) begin
                    cut_to($urandom_range(1, frame_bytes.size() - 1));
                end else if (kind >= 93) begin
                    cut_to($urandom_range(1, 3));
                end
                sent += frame_bytes.size();
                if (kind < 73 && $urandom_range(0, 99) < 30) begin
                    add_trailing($urandom_range(1, 4));
                end
                send_buffer($urandom_range(0, 99) < 80);
            end
        end
        no_gaps   = 1'b0;
        rx_stalls = 1'b1;
    endtask

    initial begin
        // every block input known from time zero
        i_rst_n                = 1'b0;
        rx_if.valid            = 1'b0;
        rx_if.rx_byte          = '0;
        rx_if.buffer_start     = 1'b0;
        rx_if.buffer_end       = 1'b0;
        res_if.ready           = 1'b0;
        cfg_if.valid           = 1'b0;
        cfg_if.expected_header = '0;
        hdr_cfg                = 8'h00;
        clear_frame_state();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_verdicts();
        test_restart();
        test_extremes();
        test_backpressure();
        test_long_buffer();
        test_random_phase(8'h00, 160, 1'b0);
        test_random_phase(8'hFF, 160, 1'b1);
        test_random_phase(8'($urandom), 160, 1'b0);
        test_random_phase(8'($urandom), 160, 1'b0);

        wait_drained();
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
